// ===== rtl/core/svt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svt_pkg
// Shared types and codes for the sorted value table.
// ----------------------------------------------------------------------------
package svt_pkg;

    localparam int TYPE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [TYPE_W-1:0]          req_type_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic [INDEX_W-1:0]         index_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic [COUNT_W-1:0]         count_out_t;

    localparam req_type_t REQ_INSERT = 2'd0;
    localparam req_type_t REQ_DELETE = 2'd1;
    localparam req_type_t REQ_READ   = 2'd2;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;
    localparam status_t ST_RANGE     = 2'd3;

endpackage : svt_pkg
`default_nettype wire

// ===== rtl/core/svt_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svt_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module svt_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire svt_pkg::value_t wdata,
    input  wire logic            re,
    input  wire logic [AW-1:0]   raddr,
    output svt_pkg::value_t      rdata
);
    import svt_pkg::*;

    value_t mem_array [DEPTH];
    value_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : svt_mem
`default_nettype wire

// ===== rtl/core/svt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svt_ctrl
// Request sequencer: scans the entry memory, shifts entries for insert and
// delete, and produces one result word per request.
// ----------------------------------------------------------------------------
module svt_ctrl #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire svt_pkg::req_type_t  req_type,
    input  wire svt_pkg::value_t     value,
    input  wire svt_pkg::index_t     index,
    output logic                     done,
    output svt_pkg::status_t         status,
    output svt_pkg::value_t          read_value,
    output svt_pkg::count_out_t      entry_count,
    output logic                     mem_we,
    output logic [AW-1:0]            mem_waddr,
    output svt_pkg::value_t          mem_wdata,
    output logic                     mem_re,
    output logic [AW-1:0]            mem_raddr,
    input  wire svt_pkg::value_t     mem_rdata
);
    import svt_pkg::*;

    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_INS0 = 5'b00100,
        S_DEL  = 5'b01000,
        S_RD   = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    value_t          val_reg, val_next;
    logic            found_reg, found_next;
    status_t         status_reg, status_next;
    value_t          rdval_reg, rdval_next;
    logic            done_reg, done_next;

    logic [CW-1:0]   ptr_m1, ptr_m2, ptr_p1, count_m1;
    logic [XW-1:0]   idx_x;
    logic            match;

    assign ptr_m1   = ptr_reg - CW'(1);
    assign ptr_m2   = ptr_reg - CW'(2);
    assign ptr_p1   = ptr_reg + CW'(1);
    assign count_m1 = count_reg - CW'(1);
    assign idx_x    = XW'(index);
    assign match    = (mem_rdata == val_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        val_next    = val_reg;
        found_next  = found_reg;
        status_next = status_reg;
        rdval_next  = rdval_reg;
        done_next   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = val_reg;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next    = value;
                    status_next = ST_OK;
                    rdval_next  = '0;
                    case (req_type)
                        REQ_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = value;
                                count_next = count_reg + CW'(1);
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = count_m1[AW-1:0];
                                ptr_next   = count_reg;
                                state_next = S_INS;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                ptr_next   = '0;
                                found_next = 1'b0;
                                state_next = S_DEL;
                            end
                        end
                        REQ_READ:
                        begin
                            if (idx_x < XW'(count_reg))
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = idx_x[AW-1:0];
                                state_next = S_RD;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                                done_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                // mem_rdata holds entry[ptr-1]
                if (mem_rdata >= val_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg[AW-1:0];
                    mem_wdata = mem_rdata;
                    ptr_next  = ptr_m1;
                    if (ptr_reg == CW'(1))
                    begin
                        state_next = S_INS0;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_m2[AW-1:0];
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = ptr_reg[AW-1:0];
                    mem_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_INS0:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_DEL:
            begin
                // mem_rdata holds entry[ptr]; after a hit, shift down by one
                if (found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_m1[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                found_next = found_reg | match;
                if (ptr_reg == count_m1)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (found_reg | match)
                    begin
                        count_next = count_m1;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_p1[AW-1:0];
                    ptr_next  = ptr_p1;
                end
            end
            S_RD:
            begin
                rdval_next = mem_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        val_reg    <= val_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = rdval_reg;
    assign entry_count = COUNT_W'(count_reg);

endmodule : svt_ctrl
`default_nettype wire

// ===== rtl/core/sorted_value_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_value_table
// Bounded ascending multiset of signed 32-bit words with insert, delete and
// indexed read; entries live in a single-port-write, registered-read memory.
// Scans run one entry per cycle: insert walks down from the top, moving up
//   entries not below the value; delete walks all entries. Read does one
//   registered read; insert into an empty table and rejections need no scan.
// Throughput: one request in flight; the next word is accepted in the cycle
//   of the done strobe. Results: receiver cannot stall.
// Reset: asynchronous rst_n clears the count and control; entries need none.
// ----------------------------------------------------------------------------
module sorted_value_table #(
    parameter int CAPACITY = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire svt_pkg::req_type_t req_type,
    input  wire svt_pkg::value_t    value,
    input  wire svt_pkg::index_t    index,
    output logic                    done,
    output svt_pkg::status_t        status,
    output svt_pkg::value_t         read_value,
    output svt_pkg::count_out_t     entry_count
);
    import svt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    value_t          mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    value_t          mem_rdata;

    svt_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .value       (value),
        .index       (index),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    svt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule : sorted_value_table
`default_nettype wire

// ===== tb/tb_sorted_value_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sorted_value_table
// Self-checking bench for the sorted value table. A short table of directed
// words (empty table, extreme values, duplicates, full table, absent delete,
// out-of-range read, unused request code) is followed by random fill, drain
// and mixed phases. A shadow table or the directed row gives each result, and
// each done strobe is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_sorted_value_table;
    timeunit 1ns;
    timeprecision 1ps;

    import svt_pkg::*;

    localparam int        CAPACITY      = 16;
    localparam int        RANDOM_WORDS  = 1700;
    localparam int        DRAIN_CYCLES  = 40;
    localparam longint    CYCLE_LIMIT   = 400000;
    localparam int        DIR_ROWS      = 26;
    localparam req_type_t REQ_NONE      = 2'd3;

    typedef struct {
        status_t    st;
        value_t     rd;
        count_out_t cnt;
    } table_result_t;

    typedef struct {
        req_type_t  kind;
        value_t     val;
        index_t     idx;
        bit         typed;
        status_t    st;
        value_t     rd;
        count_out_t cnt;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_type_t  req_type;
    value_t     value;
    index_t     index;
    logic       done;
    status_t    status;
    value_t     read_value;
    count_out_t entry_count;

    value_t        shadow_entries [CAPACITY];
    int unsigned   shadow_count;
    table_result_t pending_results [$];
    int unsigned   mismatch_count;
    longint        cycle_count;
    int unsigned   burst_left;
    dir_row_t      directed [DIR_ROWS];

    sorted_value_table #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .value      (value),
        .index      (index),
        .done       (done),
        .status     (status),
        .read_value (read_value),
        .entry_count(entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic table_result_t apply_request(req_type_t kind, value_t val, index_t idx);
        table_result_t res;
        int unsigned   pos;
        res.st  = ST_OK;
        res.rd  = '0;
        pos     = 0;
        if (kind == REQ_INSERT)
        begin
            if (shadow_count >= CAPACITY)
                res.st = ST_FULL;
            else
            begin
                while (pos < shadow_count && shadow_entries[pos] < val)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                    shadow_entries[i] = shadow_entries[i-1];
                shadow_entries[pos] = val;
                shadow_count++;
            end
        end
        else if (kind == REQ_DELETE)
        begin
            while (pos < shadow_count && shadow_entries[pos] != val)
                pos++;
            if (pos >= shadow_count)
                res.st = ST_NOT_FOUND;
            else
            begin
                for (int i = pos; i + 1 < shadow_count; i++)
                    shadow_entries[i] = shadow_entries[i+1];
                shadow_count--;
            end
        end
        else if (kind == REQ_READ)
        begin
            if (idx < shadow_count)
                res.rd = shadow_entries[idx];
            else
                res.st = ST_RANGE;
        end
        res.cnt = count_out_t'(shadow_count);
        return res;
    endfunction

    // small values give duplicates, the rest reach the extremes and every bit
    function automatic value_t pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return value_t'($signed($urandom_range(0, 8)) - 4);
        else if (r == 4)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return '0;
                default: return '1;
            endcase
        end
        return value_t'($urandom);
    endfunction

    // drive one word, wait for acceptance, record what it should return
    task automatic send_word(input req_type_t kind, input value_t val, input index_t idx,
                             input bit typed, input table_result_t typed_res);
        table_result_t predicted;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        start    <= 1'b1;
        req_type <= kind;
        value    <= val;
        index    <= idx;
        do
            @(posedge clk);
        while (busy);
        burst_left--;
        predicted = apply_request(kind, val, idx);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    always @(posedge clk)
    begin
        table_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: status %0d read %h count %0d",
                             status, read_value, entry_count);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (status !== exp_res.st || read_value !== exp_res.rd
                    || entry_count !== exp_res.cnt)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("exp st %0d rd %h cnt %0d, got st %0d rd %h cnt %0d",
                                 exp_res.st, exp_res.rd, exp_res.cnt,
                                 status, read_value, entry_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sorted_value_table: mismatch");
            $finish;
        end
    end

    initial
    begin
        table_result_t typed_res;
        table_result_t none_res;
        req_type_t     kind;
        value_t        val;
        index_t        idx;
        int unsigned   phase;
        int unsigned   phase_left;
        int unsigned   r;
        int unsigned   sent;

        rst_n          = 1'b0;
        start          = 1'b0;
        req_type       = REQ_INSERT;
        value          = '0;
        index          = '0;
        shadow_count   = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 0;
        none_res       = '{ST_OK, '0, '0};

        directed = '{
            '{REQ_READ,   32'sd0,            4'd0,  1'b1, ST_RANGE,     32'sd0,           5'd0},
            '{REQ_DELETE, 32'sd5,            4'd0,  1'b1, ST_NOT_FOUND, 32'sd0,           5'd0},
            '{REQ_NONE,   32'sh5A5A_A5A5,    4'd9,  1'b1, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, 32'sh7FFF_FFFF,    4'd0,  1'b1, ST_OK,        32'sd0,           5'd1},
            '{REQ_INSERT, 32'sh8000_0000,    4'd0,  1'b1, ST_OK,        32'sd0,           5'd2},
            '{REQ_READ,   32'sd0,            4'd0,  1'b1, ST_OK,        32'sh8000_0000,   5'd2},
            '{REQ_READ,   32'sd0,            4'd1,  1'b1, ST_OK,        32'sh7FFF_FFFF,   5'd2},
            '{REQ_READ,   32'sd0,            4'd15, 1'b1, ST_RANGE,     32'sd0,           5'd2},
            '{REQ_INSERT, 32'sd0,            4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, 32'sd0,            4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, -32'sd1,           4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, 32'sd1,            4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, 32'sd100,          4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, -32'sd100,         4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, 32'sd7,            4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, 32'sd7,            4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, 32'sd3,            4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, -32'sd3,           4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, 32'sd50,           4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, 32'sd9,            4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, 32'sd10,           4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, 32'sd11,           4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_INSERT, 32'sd5,            4'd0,  1'b1, ST_FULL,      32'sd0,           5'd16},
            '{REQ_READ,   32'sd0,            4'd15, 1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_DELETE, 32'sd7,            4'd0,  1'b0, ST_OK,        32'sd0,           5'd0},
            '{REQ_DELETE, 32'sd12345,        4'd0,  1'b1, ST_NOT_FOUND, 32'sd0,           5'd15}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            typed_res = '{directed[i].st, directed[i].rd, directed[i].cnt};
            send_word(directed[i].kind, directed[i].val, directed[i].idx,
                      directed[i].typed, typed_res);
        end

        // phases: 0 mostly fill, 1 mostly drain, 2 balanced
        sent       = 0;
        phase_left = 0;
        phase      = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (phase_left == 0)
            begin
                phase      = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            r   = $urandom_range(0, 99);
            val = value_t'($urandom);
            idx = index_t'($urandom_range(0, 15));
            if (r < (phase == 0 ? 60 : (phase == 1 ? 20 : 40)))
            begin
                kind = REQ_INSERT;
                val  = pick_value();
            end
            else if (r < (phase == 0 ? 75 : 70))
            begin
                kind = REQ_DELETE;
                if (shadow_count > 0 && $urandom_range(0, 3) != 0)
                    val = shadow_entries[$urandom_range(0, shadow_count - 1)];
                else
                    val = pick_value();
            end
            else if (r < 97)
                kind = REQ_READ;
            else
                kind = REQ_NONE;
            send_word(kind, val, idx, 1'b0, none_res);
            sent++;
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("sorted_value_table: match");
        else
            $display("sorted_value_table: mismatch");
        $finish;
    end

endmodule : tb_sorted_value_table
`default_nettype wire

// ===== filelist.f =====
rtl/core/svt_pkg.sv
rtl/core/svt_mem.sv
rtl/core/svt_ctrl.sv
rtl/core/sorted_value_table.sv
tb/tb_sorted_value_table.sv
